// ===== hw/rtl/cam_pkg.sv =====
// ============================================================================
// cam_pkg
// Shared types, S-box, sigma constants and round functions for the cipher.
// ============================================================================
package cam_pkg;

    localparam int NUM_ROUNDS = 24;
    localparam int SHORT_ROUNDS = 18;
    localparam int NUM_KE = 6;

    // register indexes of the write port
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_KLEN = 3'd4;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    localparam logic ACT_DECRYPT = 1'b1;

    typedef struct packed {
        logic        action;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } cam_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } cam_out_t;

    // word in flight between rounds
    typedef struct packed {
        logic        action;
        logic [63:0] d1;
        logic [63:0] d2;
    } cam_blk_t;

    // subkeys in encryption order
    typedef struct packed {
        logic                    short_key;
        logic [3:0][63:0]        kw;
        logic [NUM_ROUNDS-1:0][63:0] k;
        logic [NUM_KE-1:0][63:0] ke;
    } cam_keys_t;

    localparam logic [63:0] SIGMA [6] = '{
        64'hA09E667F3BCC908B, 64'hB67AE8584CAA73B2, 64'hC6EF372FE94F82BE,
        64'h54FF53A5F1D36F1C, 64'h10E527FADE682D1D, 64'hB05688C2B3E6C1FD
    };

    localparam logic [7:0] SBOX1 [256] = '{
        8'd112,8'd130,8'd44,8'd236,8'd179,8'd39,8'd192,8'd229,
        8'd228,8'd133,8'd87,8'd53,8'd234,8'd12,8'd174,8'd65,
        8'd35,8'd239,8'd107,8'd147,8'd69,8'd25,8'd165,8'd33,
        8'd237,8'd14,8'd79,8'd78,8'd29,8'd101,8'd146,8'd189,
        8'd134,8'd184,8'd175,8'd143,8'd124,8'd235,8'd31,8'd206,
        8'd62,8'd48,8'd220,8'd95,8'd94,8'd197,8'd11,8'd26,
        8'd166,8'd225,8'd57,8'd202,8'd213,8'd71,8'd93,8'd61,
        8'd217,8'd1,8'd90,8'd214,8'd81,8'd86,8'd108,8'd77,
        8'd139,8'd13,8'd154,8'd102,8'd251,8'd204,8'd176,8'd45,
        8'd116,8'd18,8'd43,8'd32,8'd240,8'd177,8'd132,8'd153,
        8'd223,8'd76,8'd203,8'd194,8'd52,8'd126,8'd118,8'd5,
        8'd109,8'd183,8'd169,8'd49,8'd209,8'd23,8'd4,8'd215,
        8'd20,8'd88,8'd58,8'd97,8'd222,8'd27,8'd17,8'd28,
        8'd50,8'd15,8'd156,8'd22,8'd83,8'd24,8'd242,8'd34,
        8'd254,8'd68,8'd207,8'd178,8'd195,8'd181,8'd122,8'd145,
        8'd36,8'd8,8'd232,8'd168,8'd96,8'd252,8'd105,8'd80,
        8'd170,8'd208,8'd160,8'd125,8'd161,8'd137,8'd98,8'd151,
        8'd84,8'd91,8'd30,8'd149,8'd224,8'd255,8'd100,8'd210,
        8'd16,8'd196,8'd0,8'd72,8'd163,8'd247,8'd117,8'd219,
        8'd138,8'd3,8'd230,8'd218,8'd9,8'd63,8'd221,8'd148,
        8'd135,8'd92,8'd131,8'd2,8'd205,8'd74,8'd144,8'd51,
        8'd115,8'd103,8'd246,8'd243,8'd157,8'd127,8'd191,8'd226,
        8'd82,8'd155,8'd216,8'd38,8'd200,8'd55,8'd198,8'd59,
        8'd129,8'd150,8'd111,8'd75,8'd19,8'd190,8'd99,8'd46,
        8'd233,8'd121,8'd167,8'd140,8'd159,8'd110,8'd188,8'd142,
        8'd41,8'd245,8'd249,8'd182,8'd47,8'd253,8'd180,8'd89,
        8'd120,8'd152,8'd6,8'd106,8'd231,8'd70,8'd113,8'd186,
        8'd212,8'd37,8'd171,8'd66,8'd136,8'd162,8'd141,8'd250,
        8'd114,8'd7,8'd185,8'd85,8'd248,8'd238,8'd172,8'd10,
        8'd54,8'd73,8'd42,8'd104,8'd60,8'd56,8'd241,8'd164,
        8'd64,8'd40,8'd211,8'd123,8'd187,8'd201,8'd67,8'd193,
        8'd21,8'd227,8'd173,8'd244,8'd119,8'd199,8'd128,8'd158
    };

    function automatic logic [7:0] sb1(input logic [7:0] v);
        return SBOX1[v];
    endfunction

    function automatic logic [7:0] sb2(input logic [7:0] v);
        logic [7:0] s;
        s = SBOX1[v];
        return {s[6:0], s[7]};
    endfunction

    function automatic logic [7:0] sb3(input logic [7:0] v);
        logic [7:0] s;
        s = SBOX1[v];
        return {s[0], s[7:1]};
    endfunction

    function automatic logic [7:0] sb4(input logic [7:0] v);
        return SBOX1[{v[6:0], v[7]}];
    endfunction

    // F function: S-layer then P-layer
    function automatic logic [63:0] feistel(input logic [63:0] din, input logic [63:0] key);
        logic [63:0] x;
        logic [7:0]  t1, t2, t3, t4, t5, t6, t7, t8;
        x  = din ^ key;
        t1 = sb1(x[63:56]);
        t2 = sb2(x[55:48]);
        t3 = sb3(x[47:40]);
        t4 = sb4(x[39:32]);
        t5 = sb2(x[31:24]);
        t6 = sb3(x[23:16]);
        t7 = sb4(x[15:8]);
        t8 = sb1(x[7:0]);
        return {t1 ^ t3 ^ t4 ^ t6 ^ t7 ^ t8,
                t1 ^ t2 ^ t4 ^ t5 ^ t7 ^ t8,
                t1 ^ t2 ^ t3 ^ t5 ^ t6 ^ t8,
                t2 ^ t3 ^ t4 ^ t5 ^ t6 ^ t7,
                t1 ^ t2 ^ t6 ^ t7 ^ t8,
                t2 ^ t3 ^ t5 ^ t7 ^ t8,
                t3 ^ t4 ^ t5 ^ t6 ^ t8,
                t1 ^ t4 ^ t5 ^ t6 ^ t7};
    endfunction

    function automatic logic [31:0] rotl1(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [63:0] fl_fwd(input logic [63:0] din, input logic [63:0] ke);
        logic [31:0] x1, x2;
        x1 = din[63:32];
        x2 = din[31:0];
        x2 = x2 ^ rotl1(x1 & ke[63:32]);
        x1 = x1 ^ (x2 | ke[31:0]);
        return {x1, x2};
    endfunction

    function automatic logic [63:0] fl_inv(input logic [63:0] din, input logic [63:0] ke);
        logic [31:0] y1, y2;
        y1 = din[63:32];
        y2 = din[31:0];
        y1 = y1 ^ (y2 | ke[31:0]);
        y2 = y2 ^ rotl1(y1 & ke[63:32]);
        return {y1, y2};
    endfunction

    // 128-bit rotate left by a constant amount
    function automatic logic [127:0] rot128(input logic [127:0] v, input int n);
        logic [255:0] t;
        t = {v, v} << n;
        return t[255:128];
    endfunction

endpackage

// ===== hw/rtl/cam_key_sched.sv =====
// ============================================================================
// cam_key_sched
// Key registers, KA/KB derivation, subkey assembly.
// ============================================================================
module cam_key_sched (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [63:0]        wr_data,
    output logic               keys_ready,
    output cam_pkg::cam_keys_t keys
);
    import cam_pkg::*;

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg;
    logic [1:0]   klen_reg;
    logic [2:0]   step_reg;
    logic         ready_reg;
    logic [63:0]  d1_reg, d2_reg;
    logic [127:0] ka_reg, kb_reg;
    logic [127:0] kl, kr;
    logic [127:0] ka_rot45, kl_rot60;
    logic [63:0]  f_in, f_out;
    logic         wr_hit;

    assign wr_hit = wr_en && (wr_index == REG_KEY0 || wr_index == REG_KEY1 ||
                              wr_index == REG_KEY2 || wr_index == REG_KEY3 ||
                              wr_index == REG_KLEN);

    // left and right key halves
    always_comb
    begin
        kl = {key0_reg, key1_reg};
        case (klen_reg)
            KLEN_128: kr = '0;
            KLEN_192: kr = {key2_reg, ~key2_reg};
            default:  kr = {key2_reg, key3_reg};
        endcase
    end

    // one shared F unit; odd steps read d1, even steps d2
    assign f_in  = step_reg[0] ? d1_reg : d2_reg;
    assign f_out = feistel(f_in, SIGMA[3'(step_reg - 3'd1)]);

    // derivation sequencer: step 0 loads, steps 1..6 run one F each
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg  <= '0;
            key1_reg  <= '0;
            key2_reg  <= '0;
            key3_reg  <= '0;
            klen_reg  <= '0;
            step_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else if (wr_hit)
        begin
            unique case (wr_index)
                REG_KEY0: key0_reg <= wr_data;
                REG_KEY1: key1_reg <= wr_data;
                REG_KEY2: key2_reg <= wr_data;
                REG_KEY3: key3_reg <= wr_data;
                default:  klen_reg <= wr_data[1:0];
            endcase
            step_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else if (!ready_reg)
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'd6)
                ready_reg <= 1'b1;
        end
    end

    // datapath of the derivation
    always_ff @(posedge clk)
    begin
        if (!ready_reg && !wr_hit)
        begin
            case (step_reg)
                3'd0:
                begin
                    d1_reg <= kl[127:64] ^ kr[127:64];
                    d2_reg <= kl[63:0] ^ kr[63:0];
                end
                3'd2:
                begin
                    d1_reg <= d1_reg ^ f_out ^ kl[127:64];
                    d2_reg <= d2_reg ^ kl[63:0];
                end
                3'd4:
                begin
                    ka_reg <= {d1_reg ^ f_out, d2_reg};
                    d1_reg <= d1_reg ^ f_out ^ kr[127:64];
                    d2_reg <= d2_reg ^ kr[63:0];
                end
                3'd6:
                    kb_reg <= {d1_reg ^ f_out, d2_reg};
                default:
                    d2_reg <= d2_reg ^ f_out;
            endcase
        end
    end

    // subkeys in encryption order, fixed rotations of KL, KR, KA, KB
    always_comb
    begin
        keys = '0;
        ka_rot45 = rot128(ka_reg, 45);
        kl_rot60 = rot128(kl, 60);
        keys.short_key = (klen_reg == KLEN_128);
        {keys.kw[0], keys.kw[1]} = kl;
        if (klen_reg == KLEN_128)
        begin
            {keys.k[0], keys.k[1]}   = ka_reg;
            {keys.k[2], keys.k[3]}   = rot128(kl, 15);
            {keys.k[4], keys.k[5]}   = rot128(ka_reg, 15);
            {keys.ke[0], keys.ke[1]} = rot128(ka_reg, 30);
            {keys.k[6], keys.k[7]}   = rot128(kl, 45);
            keys.k[8]                = ka_rot45[127:64];
            keys.k[9]                = kl_rot60[63:0];
            {keys.k[10], keys.k[11]} = rot128(ka_reg, 60);
            {keys.ke[2], keys.ke[3]} = rot128(kl, 77);
            {keys.k[12], keys.k[13]} = rot128(kl, 94);
            {keys.k[14], keys.k[15]} = rot128(ka_reg, 94);
            {keys.k[16], keys.k[17]} = rot128(kl, 111);
            {keys.kw[2], keys.kw[3]} = rot128(ka_reg, 111);
        end
        else
        begin
            {keys.k[0], keys.k[1]}   = kb_reg;
            {keys.k[2], keys.k[3]}   = rot128(kr, 15);
            {keys.k[4], keys.k[5]}   = rot128(ka_reg, 15);
            {keys.ke[0], keys.ke[1]} = rot128(kr, 30);
            {keys.k[6], keys.k[7]}   = rot128(kb_reg, 30);
            {keys.k[8], keys.k[9]}   = rot128(kl, 45);
            {keys.k[10], keys.k[11]} = ka_rot45;
            {keys.ke[2], keys.ke[3]} = kl_rot60;
            {keys.k[12], keys.k[13]} = rot128(kr, 60);
            {keys.k[14], keys.k[15]} = rot128(kb_reg, 60);
            {keys.k[16], keys.k[17]} = rot128(kl, 77);
            {keys.ke[4], keys.ke[5]} = rot128(ka_reg, 77);
            {keys.k[18], keys.k[19]} = rot128(kr, 94);
            {keys.k[20], keys.k[21]} = rot128(ka_reg, 94);
            {keys.k[22], keys.k[23]} = rot128(kl, 111);
            {keys.kw[2], keys.kw[3]} = rot128(kb_reg, 111);
        end
    end

    assign keys_ready = ready_reg;

    a_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        wr_hit |=> !ready_reg)
        else $error("key write did not restart derivation");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !ready_reg |-> step_reg <= 3'd6)
        else $error("derivation step out of range");
    a_ready_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> $past(step_reg) == 3'd6)
        else $error("keys ready before last derivation step");

endmodule

// ===== hw/rtl/cam_round.sv =====
// ============================================================================
// cam_round
// One pipeline stage: optional whitening, optional FL layer, one F round when the stage is active.
// ============================================================================
module cam_round #(
    parameter int ROUND = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vld_in,
    input  cam_pkg::cam_blk_t  blk_in,
    input  cam_pkg::cam_keys_t keys,
    output logic               vld_out,
    output cam_pkg::cam_blk_t  blk_out
);
    import cam_pkg::*;

    localparam bit HAS_FL  = (ROUND == 6) || (ROUND == 12) || (ROUND == 18);
    localparam int KE_IDX  = HAS_FL ? (ROUND / 6 - 1) * 2 : 0;
    localparam int KE_SIDX = (KE_IDX <= 2) ? 2 - KE_IDX : 0;
    localparam int K_SIDX  = (ROUND < SHORT_ROUNDS) ? SHORT_ROUNDS - 1 - ROUND : 0;

    logic        dec, active;
    logic [63:0] rk, ke_a, ke_b, d1, d2;
    logic        vld_reg;
    cam_blk_t    blk_reg;

    assign dec    = (blk_in.action == ACT_DECRYPT);
    assign active = !keys.short_key || (ROUND < SHORT_ROUNDS);

    // key selection, reversed order for decryption
    always_comb
    begin
        if (!dec)
        begin
            rk   = keys.k[ROUND];
            ke_a = keys.ke[KE_IDX];
            ke_b = keys.ke[KE_IDX + 1];
        end
        else if (keys.short_key)
        begin
            rk   = keys.k[K_SIDX];
            ke_a = keys.ke[KE_SIDX + 1];
            ke_b = keys.ke[KE_SIDX];
        end
        else
        begin
            rk   = keys.k[NUM_ROUNDS - 1 - ROUND];
            ke_a = keys.ke[NUM_KE - 1 - KE_IDX];
            ke_b = keys.ke[NUM_KE - 2 - KE_IDX];
        end
    end

    // round datapath
    always_comb
    begin
        d1 = blk_in.d1;
        d2 = blk_in.d2;
        if (ROUND == 0)
        begin
            d1 = d1 ^ (dec ? keys.kw[2] : keys.kw[0]);
            d2 = d2 ^ (dec ? keys.kw[3] : keys.kw[1]);
        end
        if (HAS_FL && active)
        begin
            d1 = fl_fwd(d1, ke_a);
            d2 = fl_inv(d2, ke_b);
        end
        if (active)
        begin
            if (ROUND % 2 == 0)
                d2 = d2 ^ feistel(d1, rk);
            else
                d1 = d1 ^ feistel(d2, rk);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (vld_in)
            blk_reg <= '{action: blk_in.action, d1: d1, d2: d2};
    end

    assign vld_out = vld_reg;
    assign blk_out = blk_reg;

endmodule

// ===== hw/rtl/camellia_block_cipher.sv =====
// ============================================================================
// camellia_block_cipher
// Camellia 128/192/256 block encrypt/decrypt, fully pipelined.
// ============================================================================
// The result strobe follows the accepting edge through 24 round stages, the first
// loaded at that edge, then the output register. Throughput: one word per cycle
// while busy is low; the pipeline itself has no stalls. busy is high after reset or a key
// register write while KA/KB are derived by one shared F unit. Reset clears
// the keys to zero and empties the pipeline. The receiver cannot stall.
module camellia_block_cipher (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cam_pkg::cam_in_t in_word,
    output logic             result_valid,
    output cam_pkg::cam_out_t result_word,
    input  logic             wr_en,
    input  logic [2:0]       wr_index,
    input  logic [63:0]      wr_data
);
    import cam_pkg::*;

    logic      keys_ready;
    cam_keys_t keys;
    logic      vld [NUM_ROUNDS+1];
    cam_blk_t  blk [NUM_ROUNDS+1];
    logic      res_vld_reg;
    cam_out_t  res_reg;
    logic      dec_out;

    cam_key_sched u_key (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .keys_ready (keys_ready),
        .keys       (keys)
    );

    assign busy   = !keys_ready;
    assign vld[0] = start && keys_ready;
    assign blk[0] = '{action: in_word.action, d1: in_word.block_high,
                      d2: in_word.block_low};

    // round pipeline
    for (genvar r = 0; r < NUM_ROUNDS; r++)
    begin : g_round
        cam_round #(.ROUND(r)) u_round (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (vld[r]),
            .blk_in  (blk[r]),
            .keys    (keys),
            .vld_out (vld[r+1]),
            .blk_out (blk[r+1])
        );
    end

    // output whitening and result register
    assign dec_out = (blk[NUM_ROUNDS].action == ACT_DECRYPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else
            res_vld_reg <= vld[NUM_ROUNDS];
    end

    always_ff @(posedge clk)
    begin
        if (vld[NUM_ROUNDS])
        begin
            res_reg.result_high <= blk[NUM_ROUNDS].d2 ^ (dec_out ? keys.kw[0] : keys.kw[2]);
            res_reg.result_low  <= blk[NUM_ROUNDS].d1 ^ (dec_out ? keys.kw[1] : keys.kw[3]);
        end
    end

    assign result_valid = res_vld_reg;
    assign result_word  = res_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> vld[1])
        else $error("accepted word did not enter the pipeline");
    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        vld[NUM_ROUNDS] |=> result_valid)
        else $error("last stage word not presented");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !vld[NUM_ROUNDS] |=> !result_valid)
        else $error("result strobe without a word");

endmodule
